// ===== src/kdt_pkg.sv =====
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types, constants and the category lookup for the device table.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W    = 3;
    localparam int NODE_W   = 64;
    localparam int EP_W     = 16;
    localparam int TYPE_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CAT_W    = 5;
    localparam int NUM_CAT  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_GET    = 3'd3,
        CMD_ALLOC  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_DUP      = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_GET,
        S_GETW,
        S_DONE
    } t_state;

    // one table row as held in the RAM
    typedef struct packed {
        logic [NODE_W-1:0] key;
        logic [EP_W-1:0]   ep;
        logic [TYPE_W-1:0] dtype;
        logic [CAT_W-1:0]  cat;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_status           status;
        logic [COUNT_W-1:0] entry_count;
        logic [SLOT_W-1:0] entry_slot;
        logic [NODE_W-1:0] entry_node;
        logic [EP_W-1:0]   entry_endpoint;
        logic [TYPE_W-1:0] entry_type;
        logic [CAT_W-1:0]  entry_category;
        logic [NODE_W-1:0] allocated_id;
    } t_result;

    localparam logic [TYPE_W-1:0] CAT_TYPES [NUM_CAT] = '{
        32'h0100, 32'h0101, 32'h0102, 32'h010D, 32'h010A, 32'h010B, 32'h0301, 32'h000A,
        32'h0202, 32'h0015, 32'h0302, 32'h0307, 32'h0107, 32'h0106, 32'h0103, 32'h002B
    };

    // category 1..16 by position in the list, 0 when unknown
    function automatic logic [CAT_W-1:0] type_category(input logic [TYPE_W-1:0] t);
        logic [CAT_W-1:0] c;
        c = '0;
        for (int i = NUM_CAT - 1; i >= 0; i--) begin
            if (CAT_TYPES[i] == t) begin
                c = CAT_W'(i + 1);
            end
        end
        return c;
    endfunction

endpackage

// ===== src/kdt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// kdt_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface kdt_cmd_if;
    import kdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_id;
    logic [EP_W-1:0]   ep_num;
    logic [TYPE_W-1:0] dev_type;
    logic [SLOT_W-1:0] slot_index;

    modport source (
        output valid, cmd, node_id, ep_num, dev_type, slot_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, node_id, ep_num, dev_type, slot_index,
        output ready
    );
endinterface

// ===== src/kdt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kdt_rsp_if
// Response channel: valid/ready handshake with the command result.
// ----------------------------------------------------------------------------
interface kdt_rsp_if;
    import kdt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic [SLOT_W-1:0]   entry_slot;
    logic [NODE_W-1:0]   entry_node;
    logic [EP_W-1:0]     entry_endpoint;
    logic [TYPE_W-1:0]   entry_type;
    logic [CAT_W-1:0]    entry_category;
    logic [NODE_W-1:0]   allocated_id;

    modport source (
        output valid, status, entry_count, entry_slot, entry_node, entry_endpoint,
               entry_type, entry_category, allocated_id,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, entry_slot, entry_node, entry_endpoint,
               entry_type, entry_category, allocated_id,
        output ready
    );
endinterface

// ===== src/kdt_ram.sv =====
// ----------------------------------------------------------------------------
// kdt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]                                 i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     i_raddr,
    output logic [WIDTH-1:0]                                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/kdt_seq.sv =====
// ----------------------------------------------------------------------------
// kdt_seq
// Command sequencer: linear key search, shift-down on remove, append on add
// and indexed read through the table RAM, and id allocation from a counter.
// ----------------------------------------------------------------------------
module kdt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kdt_cmd_if.sink           i_cmd,
    output kdt_pkg::t_result  o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output kdt_pkg::t_ram_req o_ram,
    input  kdt_pkg::t_entry   i_rdata
);
    import kdt_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [NODE_W-1:0] r_key, n_key;
    logic [EP_W-1:0]   r_ep, n_ep;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_pend_ptr, n_pend_ptr;
    logic [NODE_W-1:0] r_idctr, n_idctr;
    t_result           r_res, n_res;

    logic              hit;
    logic              scan_end;
    logic [CNT_W-1:0]  shift_dst;

    // a read issued last cycle is compared this cycle
    assign hit       = r_pend && (i_rdata.key == r_key);
    assign scan_end  = !r_pend && (r_ptr >= r_count);
    assign shift_dst = r_pend_ptr - CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_ep       = r_ep;
        n_type     = r_type;
        n_idx      = r_idx;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pend     = r_pend;
        n_pend_ptr = r_pend_ptr;
        n_idctr    = r_idctr;
        n_res      = r_res;
        o_ram      = '0;
        o_ram.raddr = r_ptr[IDX_W-1:0];
        i_cmd.ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd      = t_cmd'(i_cmd.cmd);
                    n_key      = i_cmd.node_id;
                    n_ep       = i_cmd.ep_num;
                    n_type     = i_cmd.dev_type;
                    n_idx      = i_cmd.slot_index;
                    n_res      = '0;
                    n_res.status = ST_NOTFOUND;
                    n_ptr      = '0;
                    n_pend     = 1'b0;
                    n_state    = S_DONE;
                    case (t_cmd'(i_cmd.cmd))
                        CMD_ADD: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        CMD_REMOVE, CMD_FIND: begin
                            n_state = S_SRCH;
                        end
                        CMD_GET: begin
                            if (!(32'(i_cmd.slot_index) >= 32'(r_count) ||
                                  32'(i_cmd.slot_index) >= 32'(TABLE_DEPTH))) begin
                                n_state = S_GET;
                            end
                        end
                        CMD_ALLOC: begin
                            n_res.status       = ST_OK;
                            n_res.allocated_id = r_idctr;
                            n_idctr            = r_idctr + NODE_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SRCH: begin
                if (r_ptr < r_count) begin
                    o_ram.raddr = r_ptr[IDX_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_ptr  = r_ptr;
                    n_ptr       = r_ptr + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (hit) begin
                    n_res.entry_slot     = SLOT_W'(r_pend_ptr);
                    n_res.entry_node     = i_rdata.key;
                    n_res.entry_endpoint = i_rdata.ep;
                    n_res.entry_type     = i_rdata.dtype;
                    n_res.entry_category = i_rdata.cat;
                    case (r_cmd)
                        CMD_ADD: begin
                            n_res.status = ST_DUP;
                            n_state      = S_DONE;
                        end
                        CMD_REMOVE: begin
                            n_res.status = ST_OK;
                            n_ptr        = r_pend_ptr + CNT_W'(1);
                            n_pend       = 1'b0;
                            n_state      = S_SHIFT;
                        end
                        default: begin
                            n_res.status = ST_OK;
                            n_state      = S_DONE;
                        end
                    endcase
                end else if (scan_end) begin
                    if (r_cmd == CMD_ADD) begin
                        o_ram.we             = 1'b1;
                        o_ram.waddr          = r_count[IDX_W-1:0];
                        o_ram.wdata.key      = r_key;
                        o_ram.wdata.ep       = r_ep;
                        o_ram.wdata.dtype    = r_type;
                        o_ram.wdata.cat      = type_category(r_type);
                        n_res.status         = ST_OK;
                        n_res.entry_slot     = SLOT_W'(r_count);
                        n_res.entry_node     = r_key;
                        n_res.entry_endpoint = r_ep;
                        n_res.entry_type     = r_type;
                        n_res.entry_category = type_category(r_type);
                        n_count              = r_count + CNT_W'(1);
                    end
                    n_state = S_DONE;
                end
            end

            S_SHIFT: begin
                // read row p+2 while writing row p with row p+1 from the previous read
                if (r_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = shift_dst[IDX_W-1:0];
                    o_ram.wdata = i_rdata;
                end
                if (r_ptr < r_count) begin
                    o_ram.raddr = r_ptr[IDX_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_ptr  = r_ptr;
                    n_ptr       = r_ptr + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (scan_end) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_GET: begin
                o_ram.raddr = IDX_W'(r_idx);
                n_state     = S_GETW;
            end

            S_GETW: begin
                n_res.status         = ST_OK;
                n_res.entry_slot     = r_idx;
                n_res.entry_node     = i_rdata.key;
                n_res.entry_endpoint = i_rdata.ep;
                n_res.entry_type     = i_rdata.dtype;
                n_res.entry_category = i_rdata.cat;
                n_state              = S_DONE;
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res             = r_res;
        o_res.entry_count = COUNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_idctr <= NODE_W'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_idctr <= n_idctr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_ep       <= n_ep;
        r_type     <= n_type;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_pend_ptr <= n_pend_ptr;
        r_res      <= n_res;
    end
endmodule

// ===== src/keyed_device_table.sv =====
// Timing: allocate, unused codes, add to a full table and a get out of range give their
//   result straight from idle; get reads the row; find and add scan from row 0 to the
//   match or table end, where add appends; remove then moves later rows down one place.
// Throughput: one command at a time, one RAM row per cycle; the worst case is a
//   remove of row 0 of a full table.
// Reset: synchronous; clears the entry count, sets the id counter to one, RAM undefined.
// ----------------------------------------------------------------------------
// keyed_device_table
// Compacted device table keyed by 64-bit node id, held in one RAM.
// ----------------------------------------------------------------------------
module keyed_device_table (
    input  logic    i_clk,
    input  logic    i_rst_n,
    kdt_cmd_if.sink i_cmd,
    kdt_rsp_if.source o_rsp
);
    import kdt_pkg::*;

    t_result  seq_res;
    logic     seq_res_valid;
    logic     seq_res_ready;
    t_ram_req ram_req;
    t_entry   ram_rdata;

    logic     r_out_valid;
    t_result  r_out;

    kdt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    kdt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (seq_res),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    // output register frees the sequencer while a response waits
    assign seq_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && seq_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_out <= seq_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.entry_slot     = r_out.entry_slot;
    assign o_rsp.entry_node     = r_out.entry_node;
    assign o_rsp.entry_endpoint = r_out.entry_endpoint;
    assign o_rsp.entry_type     = r_out.entry_type;
    assign o_rsp.entry_category = r_out.entry_category;
    assign o_rsp.allocated_id   = r_out.allocated_id;
endmodule

// ===== test/kdt_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdt_table_checker
// Watches the command and response channels of the device table, keeps its
// own copy of the table and the id counter, and compares every response with
// the result predicted for the oldest command still outstanding.
// ----------------------------------------------------------------------------
module kdt_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    kdt_cmd_if   i_cmd,
    kdt_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import kdt_pkg::*;

    localparam int MAX_REPORTS = 10;

    // shadow copy of the table
    logic [NODE_W-1:0] node_tbl [TABLE_DEPTH];
    logic [EP_W-1:0]   ep_tbl   [TABLE_DEPTH];
    logic [TYPE_W-1:0] type_tbl [TABLE_DEPTH];
    logic [CAT_W-1:0]  cat_tbl  [TABLE_DEPTH];
    int                entries;
    logic [NODE_W-1:0] next_id;

    t_result pending_results [$];

    function automatic logic [CAT_W-1:0] category_of(logic [TYPE_W-1:0] dtype);
        case (dtype)
            32'h0100: return 5'd1;
            32'h0101: return 5'd2;
            32'h0102: return 5'd3;
            32'h010D: return 5'd4;
            32'h010A: return 5'd5;
            32'h010B: return 5'd6;
            32'h0301: return 5'd7;
            32'h000A: return 5'd8;
            32'h0202: return 5'd9;
            32'h0015: return 5'd10;
            32'h0302: return 5'd11;
            32'h0307: return 5'd12;
            32'h0107: return 5'd13;
            32'h0106: return 5'd14;
            32'h0103: return 5'd15;
            32'h002B: return 5'd16;
            default:  return 5'd0;
        endcase
    endfunction

    function automatic int position_of(logic [NODE_W-1:0] node);
        for (int i = 0; i < entries; i++) begin
            if (node_tbl[i] == node) return i;
        end
        return -1;
    endfunction

    function automatic void show_row(inout t_result res, input int pos);
        res.entry_slot     = SLOT_W'(pos);
        res.entry_node     = node_tbl[pos];
        res.entry_endpoint = ep_tbl[pos];
        res.entry_type     = type_tbl[pos];
        res.entry_category = cat_tbl[pos];
    endfunction

    // applies one command to the shadow table and returns its response
    function automatic t_result apply_command(
        logic [CMD_W-1:0]  code,
        logic [NODE_W-1:0] node,
        logic [EP_W-1:0]   ep,
        logic [TYPE_W-1:0] dtype,
        logic [SLOT_W-1:0] slot
    );
        t_result res;
        int      hit;
        res = '0;
        res.status = ST_NOTFOUND;
        case (code)
            CMD_ADD: begin
                if (entries >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    hit = position_of(node);
                    if (hit >= 0) begin
                        res.status = ST_DUP;
                        show_row(res, hit);
                    end else begin
                        node_tbl[entries] = node;
                        ep_tbl[entries]   = ep;
                        type_tbl[entries] = dtype;
                        cat_tbl[entries]  = category_of(dtype);
                        show_row(res, entries);
                        entries++;
                        res.status = ST_OK;
                    end
                end
            end
            CMD_REMOVE: begin
                hit = position_of(node);
                if (hit >= 0) begin
                    show_row(res, hit);
                    // later rows move down; the freed top row keeps its data
                    for (int i = hit; i + 1 < entries; i++) begin
                        node_tbl[i] = node_tbl[i+1];
                        ep_tbl[i]   = ep_tbl[i+1];
                        type_tbl[i] = type_tbl[i+1];
                        cat_tbl[i]  = cat_tbl[i+1];
                    end
                    entries--;
                    res.status = ST_OK;
                end
            end
            CMD_FIND: begin
                hit = position_of(node);
                if (hit >= 0) begin
                    show_row(res, hit);
                    res.status = ST_OK;
                end
            end
            CMD_GET: begin
                if (int'(slot) < entries) begin
                    show_row(res, int'(slot));
                    res.status = ST_OK;
                end
            end
            CMD_ALLOC: begin
                res.allocated_id = next_id;
                next_id = next_id + 1'b1;
                res.status = ST_OK;
            end
            default: ;
        endcase
        res.entry_count = COUNT_W'(entries);
        return res;
    endfunction

    function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (o_fail_count < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, label, want, got);
            end
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            entries = 0;
            next_id = 64'd1;
            pending_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("%0t: response with no command outstanding", $realtime);
                    end
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 64'(want.status), 64'(i_rsp.status));
                    check_field("entry_count", 64'(want.entry_count), 64'(i_rsp.entry_count));
                    check_field("entry_slot", 64'(want.entry_slot), 64'(i_rsp.entry_slot));
                    check_field("entry_node", want.entry_node, i_rsp.entry_node);
                    check_field("entry_endpoint", 64'(want.entry_endpoint),
                                64'(i_rsp.entry_endpoint));
                    check_field("entry_type", 64'(want.entry_type), 64'(i_rsp.entry_type));
                    check_field("entry_category", 64'(want.entry_category),
                                64'(i_rsp.entry_category));
                    check_field("allocated_id", want.allocated_id, i_rsp.allocated_id);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                pending_results.push_back(apply_command(i_cmd.cmd, i_cmd.node_id,
                    i_cmd.ep_num, i_cmd.dev_type, i_cmd.slot_index));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== test/tb_keyed_device_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_device_table
// Drives directed then random device table commands with random idle cycles
// on the command channel and backpressure on the response channel; the checker predicts every response.
// ----------------------------------------------------------------------------
module tb_keyed_device_table;
    import kdt_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 9;
    localparam int RAND_ITEMS   = 850;
    localparam int KEY_POOL     = 24;
    localparam int HOLD_AT_ITEM = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 650;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 400000;

    // codes outside the defined command set
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_accepted = 0;
    int   cycle_count = 0;
    bit   idle_en = 1'b1;

    logic [NODE_W-1:0] key_pool [KEY_POOL];
    logic [NODE_W-1:0] dir_ids  [TABLE_DEPTH];

    kdt_cmd_if cmd_bus ();
    kdt_rsp_if rsp_bus ();

    keyed_device_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    kdt_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off while commands keep coming
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                rsp_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (idle_en) begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= 33);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // offers one transaction after random idle cycles, returns once accepted
    task automatic drive_cmd(
        input logic [CMD_W-1:0]  code,
        input logic [NODE_W-1:0] node,
        input logic [EP_W-1:0]   ep,
        input logic [TYPE_W-1:0] dtype,
        input logic [SLOT_W-1:0] slot
    );
        bit placed;
        placed = 1'b0;
        while (!placed) begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 99) < 33) begin
                cmd_bus.valid <= 1'b0;
            end else begin
                cmd_bus.valid      <= 1'b1;
                cmd_bus.cmd        <= code;
                cmd_bus.node_id    <= node;
                cmd_bus.ep_num     <= ep;
                cmd_bus.dev_type   <= dtype;
                cmd_bus.slot_index <= slot;
                placed = 1'b1;
            end
        end
        do @(posedge i_clk); while (!cmd_bus.ready);
        items_accepted++;
    endtask

    function automatic logic [NODE_W-1:0] rand_node();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int                r;
        logic [CMD_W-1:0]  code;
        logic [NODE_W-1:0] node;
        logic [TYPE_W-1:0] dtype;
        logic [EP_W-1:0]   ep;

        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.cmd        = CMD_ADD;
        cmd_bus.node_id    = '0;
        cmd_bus.ep_num     = '0;
        cmd_bus.dev_type   = '0;
        cmd_bus.slot_index = '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = rand_node();
        dir_ids[0] = '0;
        dir_ids[1] = '1;
        for (int i = 2; i < TABLE_DEPTH; i++) dir_ids[i] = rand_node();

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: misses, allocation, unused code
        drive_cmd(CMD_FIND, '0, '0, '0, '0);
        drive_cmd(CMD_GET, '0, '0, '0, '0);
        drive_cmd(CMD_REMOVE, '1, '0, '0, '0);
        drive_cmd(CMD_ALLOC, '0, '0, '0, '0);
        drive_cmd(CMD_RSVD_HI, '1, '1, '1, '1);

        // fill every slot, one entry per known category
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ep = (i == 0) ? '0 : (i == 1) ? '1 : EP_W'($urandom);
            drive_cmd(CMD_ADD, dir_ids[i], ep, CAT_TYPES[i], '0);
        end

        drive_cmd(CMD_ADD, rand_node(), '1, '1, '0);              // table full
        drive_cmd(CMD_REMOVE, dir_ids[7], '0, '0, '0);            // shift-down from the middle
        drive_cmd(CMD_ADD, dir_ids[1], '0, '0, '0);               // duplicate id
        drive_cmd(CMD_ADD, rand_node(), '1, '1, '0);              // unknown type, fills again
        drive_cmd(CMD_GET, '0, '0, '0, '1);                       // last slot
        drive_cmd(CMD_FIND, dir_ids[0], '0, '0, '0);
        drive_cmd(CMD_RSVD_LO, '0, '0, '0, '0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_en = !(n >= CALM_FIRST && n < CALM_LAST);
            r = $urandom_range(0, 99);
            node = ($urandom_range(0, 9) == 0) ? rand_node()
                                               : key_pool[$urandom_range(0, KEY_POOL - 1)];
            dtype = ($urandom_range(0, 1) != 0) ? CAT_TYPES[$urandom_range(0, NUM_CAT - 1)]
                                                : TYPE_W'($urandom);
            if (r < 38)      code = CMD_ADD;
            else if (r < 58) code = CMD_REMOVE;
            else if (r < 72) code = CMD_FIND;
            else if (r < 86) code = CMD_GET;
            else if (r < 94) code = CMD_ALLOC;
            else             code = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            drive_cmd(code, node, EP_W'($urandom), dtype, SLOT_W'($urandom));
        end

        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        idle_en = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
